/* rtl/polyline_curvature_check_assert.svh */
// ============================================================================
// Assertion macros for the polyline curvature checker
// Shared property forms, clocked on aclk and disabled during reset.
// ============================================================================
`ifndef POLYLINE_CURVATURE_CHECK_ASSERT_SVH
`define POLYLINE_CURVATURE_CHECK_ASSERT_SVH

// Same-cycle implication.
`define PCC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcc: same-cycle check failed");

// Next-cycle implication.
`define PCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcc: next-cycle check failed");

`endif

/* rtl/pcc_pkg.sv */
// ============================================================================
// pcc_pkg
// Types, widths and constants shared by the polyline curvature checker.
// ============================================================================
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int DIR_W      = 16;
    localparam int LEN_W      = 24;
    localparam int CNT_W      = 16;
    localparam int RAD_W      = 24;
    localparam int MINR_W     = 24;
    localparam int SHORT_W    = 10;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int MUL_A_W    = 25;
    localparam int MUL_B_W    = 41;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int NSQ_W      = 32;
    localparam int DET_W      = 33;
    localparam int ADET_W     = 32;
    localparam int QUOT_W     = 24;
    localparam int SQ_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int SREM_W     = 28;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int MUL_STEPS  = 12;
    localparam int SEQ_W      = 4;

    localparam logic [RAD_W-1:0]  RADIUS_ONES      = {RAD_W{1'b1}};
    localparam logic [MINR_W-1:0] MIN_RADIUS_FLOOR = 24'd1000;
    localparam logic [MINR_W-1:0] MIN_RADIUS_RESET = 24'd150000;
    localparam logic [SHORT_W-1:0] SHORT_RESET     = 10'd10;

    localparam logic REG_MIN_RADIUS   = 1'b0;
    localparam logic REG_SHORT_LENGTH = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_N0_AA,
        OP_N0_BB,
        OP_N1_AA,
        OP_N1_BB,
        OP_M0,
        OP_M1,
        OP_DET_P,
        OP_DET_M,
        OP_X_P,
        OP_X_Q,
        OP_Y_P,
        OP_Y_Q,
        OP_S_X,
        OP_S_Y
    } mul_op_t;

    typedef struct packed {
        logic    load_in;
        mul_op_t op;
        logic    div_init;
        logic    div_step;
        logic    sq_init;
        logic    sq_step;
        logic    out_load;
        logic    out_straight;
    } dp_cmd_t;

    typedef struct packed {
        logic straight_early;
        logic div_ovf;
        logic sq_big;
        logic out_full;
    } dp_status_t;

    function automatic mul_op_t mul_seq(input logic [SEQ_W-1:0] idx);
        mul_op_t op;
        unique case (idx)
            4'd0:    op = OP_N0_AA;
            4'd1:    op = OP_N0_BB;
            4'd2:    op = OP_N1_AA;
            4'd3:    op = OP_N1_BB;
            4'd4:    op = OP_M0;
            4'd5:    op = OP_DET_P;
            4'd6:    op = OP_M1;
            4'd7:    op = OP_DET_M;
            4'd8:    op = OP_X_P;
            4'd9:    op = OP_X_Q;
            4'd10:   op = OP_Y_P;
            4'd11:   op = OP_Y_Q;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

/* rtl/pcc_regs.sv */
// ============================================================================
// pcc_regs
// APB-style configuration registers: minimum radius and short-segment length limit.
// ============================================================================
`timescale 1ns / 1ps

module pcc_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [pcc_pkg::DATA_W-1:0]    pwdata,
    output logic [pcc_pkg::DATA_W-1:0]    prdata,
    output logic [pcc_pkg::MINR_W-1:0]    min_radius_mm,
    output logic [pcc_pkg::SHORT_W-1:0]   short_length_mm
);
    import pcc_pkg::*;

    logic [MINR_W-1:0]  min_radius_reg;
    logic [SHORT_W-1:0] short_length_reg;
    logic               wr_en;

    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_radius_reg   <= MIN_RADIUS_RESET;
            short_length_reg <= SHORT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_MIN_RADIUS:   min_radius_reg   <= pwdata[MINR_W-1:0];
                REG_SHORT_LENGTH: short_length_reg <= pwdata[SHORT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MIN_RADIUS:   prdata = DATA_W'(min_radius_reg);
            REG_SHORT_LENGTH: prdata = DATA_W'(short_length_reg);
        endcase
    end

    assign min_radius_mm   = min_radius_reg;
    assign short_length_mm = short_length_reg;

endmodule

/* rtl/pcc_ctrl.sv */
// ============================================================================
// pcc_ctrl
// Sequencer for one transaction: multiplies, division, square root, result.
// ============================================================================
`timescale 1ns / 1ps

module pcc_ctrl #(
    parameter int DIV_STEPS = 57
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pcc_pkg::dp_status_t  status,
    output pcc_pkg::dp_cmd_t     cmd
);
    import pcc_pkg::*;

    localparam int STEP_MAX = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
    localparam int CW       = $clog2(STEP_MAX + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_WAIT,
        ST_CHECK,
        ST_DIV,
        ST_DIV_END,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_WAIT,
        ST_SQ_INIT,
        ST_SQRT,
        ST_SQ_END,
        ST_FINISH
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   cnt_reg;
    logic            straight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            straight_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg    <= ST_MUL;
                        cnt_reg      <= '0;
                        straight_reg <= 1'b0;
                    end
                end
                ST_MUL: begin
                    if (cnt_reg == CW'(MUL_STEPS - 1)) begin
                        state_reg <= ST_MUL_WAIT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_MUL_WAIT: state_reg <= ST_CHECK;
                ST_CHECK: begin
                    cnt_reg <= '0;
                    if (status.straight_early) begin
                        straight_reg <= 1'b1;
                        state_reg    <= ST_FINISH;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == CW'(DIV_STEPS - 1)) begin
                        state_reg <= ST_DIV_END;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_DIV_END: begin
                    if (status.div_ovf) begin
                        straight_reg <= 1'b1;
                        state_reg    <= ST_FINISH;
                    end else begin
                        state_reg <= ST_SQ_X;
                    end
                end
                ST_SQ_X:    state_reg <= ST_SQ_Y;
                ST_SQ_Y:    state_reg <= ST_SQ_WAIT;
                ST_SQ_WAIT: state_reg <= ST_SQ_INIT;
                ST_SQ_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (cnt_reg == CW'(SQRT_STEPS - 1)) begin
                        state_reg <= ST_SQ_END;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SQ_END: begin
                    straight_reg <= status.sq_big;
                    state_reg    <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!status.out_full) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd              = '0;
        cmd.op           = OP_NONE;
        cmd.load_in      = (state_reg == ST_IDLE) & s_valid;
        cmd.div_init     = (state_reg == ST_CHECK) & ~status.straight_early;
        cmd.div_step     = (state_reg == ST_DIV);
        cmd.sq_init      = (state_reg == ST_SQ_INIT);
        cmd.sq_step      = (state_reg == ST_SQRT);
        cmd.out_load     = (state_reg == ST_FINISH) & ~status.out_full;
        cmd.out_straight = straight_reg;
        if (state_reg == ST_MUL) begin
            cmd.op = mul_seq(cnt_reg[SEQ_W-1:0]);
        end else if (state_reg == ST_SQ_X) begin
            cmd.op = OP_S_X;
        end else if (state_reg == ST_SQ_Y) begin
            cmd.op = OP_S_Y;
        end
    end

endmodule

/* rtl/pcc_dp.sv */
// ============================================================================
// pcc_dp
// Datapath: shared multiplier, two restoring dividers, integer square root,
// path state and the result register.
// ============================================================================
`timescale 1ns / 1ps

`include "polyline_curvature_check_assert.svh"

module pcc_dp #(
    parameter int DIR_FRAC_BITS = 14,
    parameter int LENGTH_BITS   = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pcc_pkg::dp_cmd_t              cmd,
    output pcc_pkg::dp_status_t           status,
    input  logic signed [pcc_pkg::DIR_W-1:0] s_dir_x,
    input  logic signed [pcc_pkg::DIR_W-1:0] s_dir_y,
    input  logic [pcc_pkg::LEN_W-1:0]     s_seg_length_mm,
    input  logic                          s_first_of_path,
    input  logic [pcc_pkg::MINR_W-1:0]    min_radius_mm,
    input  logic [pcc_pkg::SHORT_W-1:0]   short_length_mm,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [pcc_pkg::CNT_W-1:0]     m_point_number,
    output logic                          m_tight_curve,
    output logic [pcc_pkg::RAD_W-1:0]     m_radius_mm,
    output logic                          m_short_segment
);
    import pcc_pkg::*;

    localparam int F    = DIR_FRAC_BITS;
    localparam int MW   = 56 - 2 * F;
    localparam int XW   = 73 - 2 * F;
    localparam int XMW  = 72 - 2 * F;
    localparam int NW   = 71 - F;
    localparam logic [55:0] M_HALF = 56'd1 << (2 * F - 1);
    localparam logic [LEN_W-1:0] LEN_MAX = (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} :
        LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [ADET_W-1:0] PAR_LIMIT =
        ADET_W'(((64'd1 << (2 * F)) + 64'd99999) / 64'd100000);

    logic signed [DIR_W-1:0] a0_reg, b0_reg, a1_reg, b1_reg;
    logic [LEN_W-1:0]        l0_reg, l1_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    have_prev_reg;
    logic                    pair_reg;
    logic                    short_reg;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod_reg;
    mul_op_t                   dst_reg;

    logic [NSQ_W-1:0]        n0_reg, n1_reg;
    logic [MW-1:0]           m0_reg, m1_reg;
    logic signed [DET_W-1:0] det_reg;
    logic signed [XW-1:0]    x_reg, y_reg;
    logic [SQ_W-1:0]         s_reg;
    logic [55:0]             m_sum;

    logic [LEN_W-1:0]        cur_len;
    logic [DET_W-1:0]        det_neg;
    logic [ADET_W-1:0]       adet;
    logic [XW-1:0]           x_neg, y_neg;
    logic [XMW-1:0]          x_mag, y_mag;

    logic [NW-1:0]           dn_reg   [2];
    logic [ADET_W-1:0]       drem_reg [2];
    logic [QUOT_W-1:0]       q_reg    [2];
    logic                    ovf_reg  [2];
    logic [NW-1:0]           dn_next   [2];
    logic [ADET_W-1:0]       drem_next [2];
    logic [QUOT_W-1:0]       q_next    [2];
    logic                    ovf_next  [2];
    logic [ADET_W:0]         drem_sh   [2];

    logic [SQ_W-1:0]         sv_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [SREM_W-1:0]       srem_reg;
    logic [SREM_W-1:0]       srem_sh;
    logic [SREM_W-1:0]       trial;

    logic [MINR_W-1:0]       min_eff;
    logic [RAD_W-1:0]        radius;
    logic                    m_valid_reg;
    logic [CNT_W-1:0]        pn_reg;
    logic                    tight_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic                    oshort_reg;

    assign cur_len = (s_seg_length_mm > LEN_MAX) ? LEN_MAX : s_seg_length_mm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a0_reg        <= '0;
            b0_reg        <= '0;
            l0_reg        <= '0;
            cnt_reg       <= '0;
            have_prev_reg <= 1'b0;
        end else begin
            if (cmd.load_in) begin
                have_prev_reg <= 1'b1;
                if (s_first_of_path) begin
                    cnt_reg <= CNT_W'(1);
                end else if (cnt_reg != {CNT_W{1'b1}}) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                a0_reg <= a1_reg;
                b0_reg <= b1_reg;
                l0_reg <= l1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a1_reg    <= s_dir_x;
            b1_reg    <= s_dir_y;
            l1_reg    <= cur_len;
            pair_reg  <= have_prev_reg & ~s_first_of_path;
            short_reg <= (cur_len < LEN_W'(short_length_mm));
        end
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.op)
            OP_N0_AA: begin op_a = MUL_A_W'(a0_reg); op_b = MUL_B_W'(a0_reg); end
            OP_N0_BB: begin op_a = MUL_A_W'(b0_reg); op_b = MUL_B_W'(b0_reg); end
            OP_N1_AA: begin op_a = MUL_A_W'(a1_reg); op_b = MUL_B_W'(a1_reg); end
            OP_N1_BB: begin op_a = MUL_A_W'(b1_reg); op_b = MUL_B_W'(b1_reg); end
            OP_M0: begin
                op_a = $signed(MUL_A_W'(l0_reg));
                op_b = $signed(MUL_B_W'(n0_reg));
            end
            OP_M1: begin
                op_a = $signed(MUL_A_W'(l1_reg));
                op_b = $signed(MUL_B_W'(n1_reg));
            end
            OP_DET_P: begin op_a = MUL_A_W'(a0_reg); op_b = MUL_B_W'(b1_reg); end
            OP_DET_M: begin op_a = MUL_A_W'(a1_reg); op_b = MUL_B_W'(b0_reg); end
            OP_X_P: begin op_a = MUL_A_W'(b0_reg); op_b = $signed(MUL_B_W'(m1_reg)); end
            OP_X_Q: begin op_a = MUL_A_W'(b1_reg); op_b = $signed(MUL_B_W'(m0_reg)); end
            OP_Y_P: begin op_a = MUL_A_W'(a0_reg); op_b = $signed(MUL_B_W'(m1_reg)); end
            OP_Y_Q: begin op_a = MUL_A_W'(a1_reg); op_b = $signed(MUL_B_W'(m0_reg)); end
            OP_S_X: begin
                op_a = $signed(MUL_A_W'(q_reg[0]));
                op_b = $signed(MUL_B_W'(q_reg[0]));
            end
            OP_S_Y: begin
                op_a = $signed(MUL_A_W'(q_reg[1]));
                op_b = $signed(MUL_B_W'(q_reg[1]));
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dst_reg <= OP_NONE;
        end else begin
            dst_reg <= cmd.op;
        end
    end

    assign m_sum = prod_reg[55:0] + M_HALF;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        unique case (dst_reg)
            OP_N0_AA: n0_reg  <= prod_reg[NSQ_W-1:0];
            OP_N0_BB: n0_reg  <= n0_reg + prod_reg[NSQ_W-1:0];
            OP_N1_AA: n1_reg  <= prod_reg[NSQ_W-1:0];
            OP_N1_BB: n1_reg  <= n1_reg + prod_reg[NSQ_W-1:0];
            OP_M0:    m0_reg  <= MW'(m_sum >> (2 * F));
            OP_M1:    m1_reg  <= MW'(m_sum >> (2 * F));
            OP_DET_P: det_reg <= DET_W'(prod_reg);
            OP_DET_M: det_reg <= det_reg - DET_W'(prod_reg);
            OP_X_P:   x_reg   <= XW'(prod_reg);
            OP_X_Q:   x_reg   <= x_reg + XW'(prod_reg);
            OP_Y_P:   y_reg   <= XW'(prod_reg);
            OP_Y_Q:   y_reg   <= y_reg + XW'(prod_reg);
            OP_S_X:   s_reg   <= prod_reg[SQ_W-1:0];
            OP_S_Y:   s_reg   <= s_reg + prod_reg[SQ_W-1:0];
            default:  ;
        endcase
    end

    assign det_neg = -det_reg;
    assign adet    = det_reg[DET_W-1] ? det_neg[ADET_W-1:0] : det_reg[ADET_W-1:0];
    assign x_neg   = -x_reg;
    assign y_neg   = -y_reg;
    assign x_mag   = x_reg[XW-1] ? x_neg[XMW-1:0] : x_reg[XMW-1:0];
    assign y_mag   = y_reg[XW-1] ? y_neg[XMW-1:0] : y_reg[XMW-1:0];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            drem_sh[i] = {drem_reg[i], dn_reg[i][NW-1]};
            dn_next[i] = {dn_reg[i][NW-2:0], 1'b0};
            ovf_next[i] = ovf_reg[i] | q_reg[i][QUOT_W-1];
            if (drem_sh[i] >= {1'b0, adet}) begin
                drem_next[i] = ADET_W'(drem_sh[i] - {1'b0, adet});
                q_next[i]    = {q_reg[i][QUOT_W-2:0], 1'b1};
            end else begin
                drem_next[i] = drem_sh[i][ADET_W-1:0];
                q_next[i]    = {q_reg[i][QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            dn_reg[0]   <= {x_mag, {(F - 1){1'b0}}};
            dn_reg[1]   <= {y_mag, {(F - 1){1'b0}}};
            for (int i = 0; i < 2; i++) begin
                drem_reg[i] <= '0;
                q_reg[i]    <= '0;
                ovf_reg[i]  <= 1'b0;
            end
        end else if (cmd.div_step) begin
            for (int i = 0; i < 2; i++) begin
                dn_reg[i]   <= dn_next[i];
                drem_reg[i] <= drem_next[i];
                q_reg[i]    <= q_next[i];
                ovf_reg[i]  <= ovf_next[i];
            end
        end
    end

    assign srem_sh = {srem_reg[SREM_W-3:0], sv_reg[SQ_W-1:SQ_W-2]};
    assign trial   = SREM_W'({root_reg, 2'b01});

    always_ff @(posedge aclk) begin
        if (cmd.sq_init) begin
            sv_reg   <= s_reg;
            root_reg <= '0;
            srem_reg <= '0;
        end else if (cmd.sq_step) begin
            sv_reg <= {sv_reg[SQ_W-3:0], 2'b00};
            if (srem_sh >= trial) begin
                srem_reg <= srem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                srem_reg <= srem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign status.straight_early = ~pair_reg
                                 | (l0_reg < LEN_W'(short_length_mm))
                                 | (l1_reg < LEN_W'(short_length_mm))
                                 | (adet < PAR_LIMIT);
    assign status.div_ovf  = ovf_reg[0] | ovf_reg[1];
    assign status.sq_big   = (root_reg >= ROOT_W'(RADIUS_ONES));
    assign status.out_full = m_valid_reg & ~m_ready;

    assign min_eff = (min_radius_mm < MIN_RADIUS_FLOOR) ? MIN_RADIUS_FLOOR : min_radius_mm;
    assign radius  = cmd.out_straight ? RADIUS_ONES : root_reg[RAD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            pn_reg     <= cnt_reg;
            radius_reg <= radius;
            tight_reg  <= ~cmd.out_straight & (radius < min_eff);
            oshort_reg <= short_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_point_number  = pn_reg;
    assign m_tight_curve   = tight_reg;
    assign m_radius_mm     = radius_reg;
    assign m_short_segment = oshort_reg;

    `PCC_ASSERT_NEXT(a_load_gives_valid, cmd.out_load, m_valid_reg)
    `PCC_ASSERT_IMPL(a_tight_not_ones, m_valid_reg && tight_reg, radius_reg != RADIUS_ONES)
    `PCC_ASSERT_IMPL(a_div_nonzero, cmd.div_step, adet >= PAR_LIMIT)

endmodule

/* rtl/polyline_curvature_check.sv */
// ============================================================================
// polyline_curvature_check
// Curve radius between consecutive path segments, with tight-curve and
// short-segment flags.
// ============================================================================
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  dir_x, dir_y, seg_length_mm, first_of_path
// m_        out        m_valid / m_ready  point_number, tight_curve, radius_mm,
//                                         short_segment
// apb       in         psel/penable       min_radius_mm (0x0), short_length_mm (0x4)
//
// A transaction ends early when the pair counts as straight before the
// division, or when a centre coordinate saturates; otherwise it runs on
// through the square root.
// Its length is set by the shared multiplier sequence, the bit-serial dividers
// and the 25-step square root. One transaction is processed at a time.
// A finished result waits in the output register while the next transaction
// is accepted. Reset is synchronous and active low.
// ============================================================================
`timescale 1ns / 1ps

module polyline_curvature_check #(
    parameter int DIR_FRAC_BITS = 14,
    parameter int LENGTH_BITS   = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pcc_pkg::DIR_W-1:0]   s_dir_x,
    input  logic signed [pcc_pkg::DIR_W-1:0]   s_dir_y,
    input  logic [pcc_pkg::LEN_W-1:0]          s_seg_length_mm,
    input  logic                               s_first_of_path,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pcc_pkg::CNT_W-1:0]          m_point_number,
    output logic                               m_tight_curve,
    output logic [pcc_pkg::RAD_W-1:0]          m_radius_mm,
    output logic                               m_short_segment,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pcc_pkg::ADDR_W-1:0]         paddr,
    input  logic [pcc_pkg::DATA_W-1:0]         pwdata,
    output logic [pcc_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import pcc_pkg::*;

    dp_cmd_t            cmd;
    dp_status_t         status;
    logic [MINR_W-1:0]  min_radius_mm;
    logic [SHORT_W-1:0] short_length_mm;

    assign pready = 1'b1;

    pcc_regs u_regs (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .min_radius_mm   (min_radius_mm),
        .short_length_mm (short_length_mm)
    );

    pcc_ctrl #(
        .DIV_STEPS (71 - DIR_FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pcc_dp #(
        .DIR_FRAC_BITS (DIR_FRAC_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_dir_x         (s_dir_x),
        .s_dir_y         (s_dir_y),
        .s_seg_length_mm (s_seg_length_mm),
        .s_first_of_path (s_first_of_path),
        .min_radius_mm   (min_radius_mm),
        .short_length_mm (short_length_mm),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_point_number  (m_point_number),
        .m_tight_curve   (m_tight_curve),
        .m_radius_mm     (m_radius_mm),
        .m_short_segment (m_short_segment)
    );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Polyline curvature checker testbench
// Drives path segments through the input channel, predicts every result from
// an independent integer model of the bisector intersection, and compares each
// result transaction with the oldest prediction. Register settings are changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class radius_scoreboard;
    typedef struct packed {
        logic [15:0] point_number;
        logic        tight_curve;
        logic [23:0] radius_mm;
        logic        short_segment;
    } radius_result_t;

    radius_result_t pending[$];
    int mismatches;

    logic [23:0] min_radius;
    logic [9:0]  short_limit;
    longint      prev_x, prev_y;
    longint unsigned prev_len;
    int          seg_count;
    bit          have_prev;

    function void clear();
        min_radius = pcc_pkg::MIN_RADIUS_RESET;
        short_limit = pcc_pkg::SHORT_RESET;
        prev_x = 0;
        prev_y = 0;
        prev_len = 0;
        seg_count = 0;
        have_prev = 0;
        mismatches = 0;
        pending.delete();
    endfunction

    function longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function bit centre_coord(longint unsigned num, longint unsigned den,
                              output longint unsigned q);
        longint unsigned q1, r, v;
        q1 = num / den;
        r = num % den;
        q = 0;
        if (q1 >= 64'd1 << 24) return 0;
        v = (q1 << 13) + (r << 13) / den;
        if (v >= 64'd1 << 24) return 0;
        q = v;
        return 1;
    endfunction

    function longint unsigned weighted_len(longint unsigned len, longint a, longint b);
        longint unsigned n;
        n = longint'(a * a + b * b);
        return (len * n + (64'd1 << 27)) >> 28;
    endfunction

    function logic [23:0] curve_radius(longint a1, longint b1, longint unsigned l1);
        longint det, x, y;
        longint unsigned adet, m0, m1, xc, yc, r;
        if (prev_len < short_limit || l1 < short_limit) return 24'hFFFFFF;
        det = prev_x * b1 - a1 * prev_y;
        adet = det < 0 ? -det : det;
        if (adet * 100000 < (64'd1 << 28)) return 24'hFFFFFF;
        m0 = weighted_len(prev_len, prev_x, prev_y);
        m1 = weighted_len(l1, a1, b1);
        x = prev_y * longint'(m1) + b1 * longint'(m0);
        y = prev_x * longint'(m1) + a1 * longint'(m0);
        if (!centre_coord(x < 0 ? -x : x, adet, xc)) return 24'hFFFFFF;
        if (!centre_coord(y < 0 ? -y : y, adet, yc)) return 24'hFFFFFF;
        r = root_floor(xc * xc + yc * yc);
        if (r >= 24'hFFFFFF) return 24'hFFFFFF;
        return r[23:0];
    endfunction

    function void note_segment(logic signed [15:0] dx, logic signed [15:0] dy,
                               logic [23:0] len, logic first);
        radius_result_t e;
        logic [23:0] minr;
        minr = min_radius < 1000 ? 24'd1000 : min_radius;
        if (first) begin
            seg_count = 1;
            have_prev = 0;
        end else if (seg_count < 65535) begin
            seg_count++;
        end
        e.radius_mm = 24'hFFFFFF;
        e.tight_curve = 0;
        if (have_prev) begin
            e.radius_mm = curve_radius(dx, dy, len);
            e.tight_curve = e.radius_mm != 24'hFFFFFF && e.radius_mm < minr;
        end
        e.point_number = seg_count[15:0];
        e.short_segment = len < short_limit;
        pending.insert(pending.size(), e);
        prev_x = dx;
        prev_y = dy;
        prev_len = len;
        have_prev = 1;
    endfunction

    function void check_result(radius_result_t got);
        radius_result_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction %h", got);
            return;
        end
        e = pending.pop_front();
        if (e !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: point exp %0d got %0d, tight exp %b got %b, radius exp %0d got %0d, short exp %b got %b",
                         e.point_number, got.point_number, e.tight_curve, got.tight_curve,
                         e.radius_mm, got.radius_mm, e.short_segment, got.short_segment);
        end
    endfunction
endclass

module testbench;
    import pcc_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [DIR_W-1:0] s_dir_x = 0;
    logic signed [DIR_W-1:0] s_dir_y = 0;
    logic [LEN_W-1:0] s_seg_length_mm = 0;
    logic s_first_of_path = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [CNT_W-1:0] m_point_number;
    logic m_tight_curve;
    logic [RAD_W-1:0] m_radius_mm;
    logic m_short_segment;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [DATA_W-1:0] pwdata = 0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    radius_scoreboard board;
    bit calm = 0;
    bit hold_results = 0;

    polyline_curvature_check DUT (.*);

    always #5 aclk = ~aclk;

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_MIN_RADIUS) board.min_radius = value[23:0];
        else board.short_limit = value[9:0];
    endtask

    task automatic send_segment(input logic signed [15:0] dx, input logic signed [15:0] dy,
                                input logic [23:0] len, input logic first);
        @(posedge aclk);
        while (!calm && $urandom_range(99) < 37) @(posedge aclk);
        s_valid <= 1;
        s_dir_x <= dx;
        s_dir_y <= dy;
        s_seg_length_mm <= len;
        s_first_of_path <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_segment(dx, dy, len, first);
        s_valid <= 0;
    endtask

    task automatic wait_idle();
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic random_segment(input bit noisy, input bit first);
        int ang;
        real th;
        logic signed [15:0] dx, dy;
        logic [23:0] len;
        if (noisy) begin
            dx = 16'($urandom);
            dy = 16'($urandom);
        end else begin
            ang = $urandom_range(3599);
            th = ang * 3.14159265 / 1800.0;
            dx = 16'($rtoi($cos(th) * 16384.0));
            dy = 16'($rtoi($sin(th) * 16384.0));
        end
        case ($urandom_range(3))
            0: len = 24'($urandom_range(40));
            1: len = 24'($urandom_range(100000));
            2: len = 24'($urandom_range(5000000));
            default: len = 24'($urandom);
        endcase
        send_segment(dx, dy, len, first);
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            board.check_result('{m_point_number, m_tight_curve, m_radius_mm, m_short_segment});
    end

    initial begin : result_side
        int k;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_ready <= 0;
                for (k = 0; k < 600; k++) @(posedge aclk);
                hold_results = 0;
            end
            m_ready <= calm || $urandom_range(99) >= 37;
        end
    end

    initial begin
        #50_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        int i, phase;
        board = new();
        board.clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        send_segment(16384, 0, 1000, 0);
        send_segment(0, 16384, 1000, 0);
        send_segment(-16384, 0, 24'hFFFFFF, 0);
        send_segment(0, -16384, 0, 0);
        send_segment(16384, 0, 9, 1);
        send_segment(16384, 0, 5000, 0);
        send_segment(16384, 1, 5000, 0);
        send_segment(11585, 11585, 200000, 0);
        send_segment(16'sh7FFF, 16'sh8000, 24'hFFFFFF, 0);
        send_segment(16'sh8000, 16'sh7FFF, 24'hFFFFFF, 0);
        send_segment(16384, 16384, 10, 1);
        send_segment(-16384, 16384, 10, 0);
        send_segment(0, 0, 100, 0);
        send_segment(16384, 0, 1000, 0);
        wait_idle();
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_register(REG_MIN_RADIUS, 1000); write_register(REG_SHORT_LENGTH, 0); end
                1: begin write_register(REG_MIN_RADIUS, 24'hFFFFFF); write_register(REG_SHORT_LENGTH, 1023); end
                2: begin write_register(REG_MIN_RADIUS, 0); write_register(REG_SHORT_LENGTH, 10); end
                3: begin write_register(REG_MIN_RADIUS, $urandom); write_register(REG_SHORT_LENGTH, $urandom); end
                4: begin write_register(REG_MIN_RADIUS, 500000); write_register(REG_SHORT_LENGTH, 1); end
                default: begin write_register(REG_MIN_RADIUS, 150000); write_register(REG_SHORT_LENGTH, 20); end
            endcase
            calm = phase == 2;
            if (phase == 1) hold_results = 1;
            for (i = 0; i < 215; i++)
                random_segment($urandom_range(9) == 0, $urandom_range(15) == 0);
            calm = 0;
            wait_idle();
        end
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
